FILE: design/fpq_pkg.sv
package fpq_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int PQ_ADDR_BITS = 10;
  localparam int PQ_DEPTH     = 1 << PQ_ADDR_BITS;

  localparam int WORD_W = 16;
  localparam int CODE_W = 10;
  localparam int NITS_W = 14;
  localparam int Y_OFS  = 64;
  localparam int C_OFS  = 512;

  // Colour matrix scaled so all three channels share one divisor:
  // channel_q = round(n * 2^(FRAC_BITS-12) / PIX_DIV)
  localparam int NW        = 35;
  localparam int PIX_SHIFT = FRAC_BITS - 12;
  localparam int EW        = NW + PIX_SHIFT;

  localparam logic signed [NW-1:0] COEF_Y  = NW'(4480000);
  localparam logic signed [NW-1:0] COEF_RV = NW'(6458748);
  localparam logic signed [NW-1:0] COEF_GU = NW'(720729);
  localparam logic signed [NW-1:0] COEF_GV = NW'(2502513);
  localparam logic signed [NW-1:0] COEF_BU = NW'(8240532);

  localparam longint PIX_DIV = 958125;
  localparam longint ONE     = 64'sd1 <<< FRAC_BITS;
  localparam int     QW      = FRAC_BITS + 1;
  localparam longint DIV_LIM = (ONE + 1) * PIX_DIV;
  localparam int     DW      = $clog2(DIV_LIM);

  // Reciprocal divide on the top bits of the dividend, then one correction step
  localparam int     DHI_W    = 26;
  localparam int     DROP     = DW - DHI_W;
  localparam int     RECIP_SH = 32;
  localparam longint RECIP    = (64'sd1 <<< (DROP + RECIP_SH)) / PIX_DIV;
  localparam int     RW       = $clog2(RECIP + 1);

  localparam logic [RW-1:0]        RECIP_V = RW'(RECIP);
  localparam logic [DW-1:0]        DIV_V   = DW'(PIX_DIV);
  localparam logic [QW-1:0]        ONE_V   = QW'(ONE);
  localparam logic signed [EW-1:0] DIV_S   = EW'(PIX_DIV);
  localparam logic signed [EW-1:0] LIM_S   = EW'(DIV_LIM);
  localparam logic signed [EW-1:0] HALF_S  = EW'(PIX_DIV / 2);
  localparam int                   AQ      = QW + PQ_ADDR_BITS;

  localparam logic [NITS_W-1:0] NITS_MAX = NITS_W'(10000);

  localparam longint Q30     = 64'sd1 <<< 30;
  localparam longint LN2_Q30 = 744261118;
  localparam longint TBL_TOP = PQ_DEPTH - 1;

  typedef logic [NITS_W-1:0] pq_rom_t [PQ_DEPTH];

  // shift-subtract quotient, n >= 0, 0 < d < 2^62
  function automatic longint pq_udiv(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((n >>> i) & 64'sd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'sd1 <<< i);
      end
    end
    return q;
  endfunction

  function automatic longint pq_log2(longint x_in);
    longint x;
    longint n;
    longint frac;
    x    = x_in;
    n    = 0;
    frac = 0;
    while (x < Q30) begin
      x = x <<< 1;
      n = n + 1;
    end
    for (int i = 29; i >= 0; i--) begin
      x = (x * x) >>> 30;
      if (x >= 2 * Q30) begin
        x    = x >>> 1;
        frac = frac | (64'sd1 <<< i);
      end
    end
    return frac - n * Q30;
  endfunction

  function automatic longint pq_exp2(longint v);
    longint a;
    longint ip;
    longint fr;
    longint y;
    longint sum;
    longint term;
    longint r;
    a    = -v;
    ip   = a >>> 30;
    fr   = a & (Q30 - 1);
    y    = (fr * LN2_Q30) >>> 30;
    sum  = Q30;
    term = Q30;
    for (int k = 1; k < 24 && term > 0; k++) begin
      term = pq_udiv((term * y) >>> 30, longint'(k));
      sum  = sum + term;
    end
    r = pq_udiv(64'sd1 <<< 60, sum);
    if (ip >= 62) return 0;
    return r >>> ip;
  endfunction

  // x^(32/2523)
  function automatic longint pq_pow_m2(longint x);
    longint n;
    longint l;
    n = pq_log2(x) * 32;
    if (n >= 0) l = (n + 2523 / 2) / 2523;
    else        l = -((-n + 2523 / 2) / 2523);
    if (l > 0) l = 0;
    return pq_exp2(l);
  endfunction

  // x^(8192/1305)
  function automatic longint pq_pow_m1(longint x);
    longint n;
    longint l;
    n = pq_log2(x) * 8192;
    if (n >= 0) l = (n + 1305 / 2) / 1305;
    else        l = -((-n + 1305 / 2) / 1305);
    if (l > 0) l = 0;
    return pq_exp2(l);
  endfunction

  function automatic longint pq_nits(longint e_in);
    longint e;
    longint ep;
    longint num;
    longint den;
    longint ratio;
    longint lum;
    longint nits;
    e = e_in;
    if (e <= 0) return 0;
    if (e > Q30) e = Q30;
    ep  = pq_pow_m2(e);
    num = ep - (64'sd107 <<< 23);
    if (num <= 0) return 0;
    den   = (64'sd2413 <<< 23) - ((64'sd2392 * ep) >>> 7);
    ratio = pq_udiv(num <<< 30, den);
    if (ratio <= 0) return 0;
    if (ratio > Q30) ratio = Q30;
    lum  = pq_pow_m1(ratio);
    nits = (lum * 10000 + (Q30 >>> 1)) >>> 30;
    if (nits > 10000) nits = 10000;
    return nits;
  endfunction

  function automatic pq_rom_t pq_build();
    pq_rom_t rom;
    longint  e;
    for (int a = 0; a < PQ_DEPTH; a++) begin
      e      = (longint'(a) * Q30 + TBL_TOP / 2) / TBL_TOP;
      rom[a] = NITS_W'(pq_nits(e));
    end
    return rom;
  endfunction

endpackage

FILE: design/p010_frame_peak_pq_nits.sv
// Frame peak estimator for sampled P010 PQ pixels. One sample request is taken per
// cycle while in_ready_o is high; each is converted to BT.2020 R'G'B' and folded into
// a running max. The request flagged frame_last yields one result after the colour
// matrix, max, frame merge, a four-stage reciprocal divide to Q16, table address,
// then the registered read of the 1024 x 14-bit PQ EOTF ROM; other requests yield
// nothing. Each stage holds one request and moves on whenever the next is free, so
// in_ready_o drops only when every stage is occupied and the output is stalled.
// peak_valid_o is low, with peak_nits_o zero, when the frame max is not positive.
module p010_frame_peak_pq_nits (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fpq_pkg::WORD_W-1:0]  luma_word_i,
  input  logic [fpq_pkg::WORD_W-1:0]  cb_word_i,
  input  logic [fpq_pkg::WORD_W-1:0]  cr_word_i,
  input  logic                        frame_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fpq_pkg::NITS_W-1:0]  peak_nits_o,
  output logic                        peak_valid_o
);

  localparam int NSTG      = 10;
  localparam int MERGE_STG = 3;
  localparam int CW        = fpq_pkg::CODE_W;
  localparam int NW        = fpq_pkg::NW;
  localparam int EW        = fpq_pkg::EW;
  localparam int DW        = fpq_pkg::DW;
  localparam int QW        = fpq_pkg::QW;
  localparam int RW        = fpq_pkg::RW;
  localparam int PW        = fpq_pkg::DHI_W + RW;
  localparam int AQ        = fpq_pkg::AQ;
  localparam int AW        = fpq_pkg::PQ_ADDR_BITS;

  localparam fpq_pkg::pq_rom_t PQ_ROM = fpq_pkg::pq_build();

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] rdy;

  logic [CW-1:0] y0_q, cb0_q, cr0_q;
  logic          last0_q;

  logic signed [NW-1:0] nr1_q, ng1_q, nb1_q;
  logic                 last1_q;

  logic signed [NW-1:0] pix2_q;
  logic                 last2_q;

  logic                 seen_q;
  logic signed [NW-1:0] run_q;
  logic signed [NW-1:0] fmax3_q;

  logic [DW-1:0] d4_q;
  logic          pos4_q, clip4_q;

  logic [QW-1:0] qest5_q;
  logic [DW-1:0] d5_q;
  logic          pos5_q, clip5_q;

  logic [DW-1:0] prod6_q;
  logic [QW-1:0] qest6_q;
  logic [DW-1:0] d6_q;
  logic          pos6_q, clip6_q;

  logic [QW-1:0] q7_q;
  logic          pos7_q;

  logic [AW-1:0] addr8_q;
  logic          pos8_q;

  logic [fpq_pkg::NITS_W-1:0] nits9_q;
  logic                       pos9_q;

  // stage 1: colour matrix
  logic signed [CW:0]   y_s, cb_s, cr_s;
  logic signed [NW-1:0] ty_s;
  logic signed [NW-1:0] nr_d, ng_d, nb_d;

  always_comb begin
    y_s  = $signed({1'b0, y0_q})  - $signed((CW + 1)'(fpq_pkg::Y_OFS));
    cb_s = $signed({1'b0, cb0_q}) - $signed((CW + 1)'(fpq_pkg::C_OFS));
    cr_s = $signed({1'b0, cr0_q}) - $signed((CW + 1)'(fpq_pkg::C_OFS));
    ty_s = NW'(y_s) * fpq_pkg::COEF_Y;
    nr_d = ty_s + NW'(cr_s) * fpq_pkg::COEF_RV;
    ng_d = ty_s - NW'(cb_s) * fpq_pkg::COEF_GU - NW'(cr_s) * fpq_pkg::COEF_GV;
    nb_d = ty_s + NW'(cb_s) * fpq_pkg::COEF_BU;
  end

  // stage 2: pixel max; stage 3: frame merge
  logic signed [NW-1:0] mrg_s, pix_d, fmax_d;

  always_comb begin
    mrg_s  = (nr1_q > ng1_q) ? nr1_q : ng1_q;
    pix_d  = (nb1_q > mrg_s) ? nb1_q : mrg_s;
    fmax_d = (seen_q && run_q > pix2_q) ? run_q : pix2_q;
  end

  // stage 4: dividend with rounding half, range flags
  logic signed [EW-1:0] dfull_s;
  logic                 pos_d, clip_d;

  always_comb begin
    dfull_s = (EW'(fmax3_q) <<< fpq_pkg::PIX_SHIFT) + fpq_pkg::HALF_S;
    pos_d   = dfull_s >= fpq_pkg::DIV_S;
    clip_d  = dfull_s >= fpq_pkg::LIM_S;
  end

  // stages 5..7: reciprocal estimate, back-multiply, correction and clamp
  logic [PW-1:0] prod5_s;
  logic [DW-1:0] prod6_d;
  logic [DW-1:0] rem7_s;
  logic [QW-1:0] q7_d;

  always_comb begin
    prod5_s = PW'(d4_q[DW-1:fpq_pkg::DROP]) * PW'(fpq_pkg::RECIP_V);
    prod6_d = DW'(qest5_q) * fpq_pkg::DIV_V;
    rem7_s  = d6_q - prod6_q;
    priority if (clip6_q) begin
      q7_d = fpq_pkg::ONE_V;
    end else if (rem7_s >= fpq_pkg::DIV_V) begin
      q7_d = qest6_q + QW'(1);
    end else begin
      q7_d = qest6_q;
    end
  end

  // stage 8: table address
  logic [AQ-1:0] asum_s;

  always_comb begin
    asum_s = AQ'(q7_q) * AQ'(fpq_pkg::PQ_DEPTH - 1) + AQ'(fpq_pkg::ONE / 2);
  end

  // stall ripples back only through occupied stages
  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o   = rdy[0];
  assign out_valid_o  = vld_q[NSTG-1];
  assign peak_nits_o  = nits9_q;
  assign peak_valid_o = pos9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= (k == MERGE_STG) ? (vld_q[k-1] && last2_q) : vld_q[k-1];
        end
      end
      if (vld_q[MERGE_STG-1] && rdy[MERGE_STG]) begin
        seen_q <= !last2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      y0_q    <= luma_word_i[fpq_pkg::WORD_W-1 -: CW];
      cb0_q   <= cb_word_i[fpq_pkg::WORD_W-1 -: CW];
      cr0_q   <= cr_word_i[fpq_pkg::WORD_W-1 -: CW];
      last0_q <= frame_last_i;
    end
    if (rdy[1]) begin
      nr1_q   <= nr_d;
      ng1_q   <= ng_d;
      nb1_q   <= nb_d;
      last1_q <= last0_q;
    end
    if (rdy[2]) begin
      pix2_q  <= pix_d;
      last2_q <= last1_q;
    end
    if (vld_q[MERGE_STG-1] && rdy[MERGE_STG] && !last2_q) begin
      run_q <= fmax_d;
    end
    if (rdy[3]) begin
      fmax3_q <= fmax_d;
    end
    if (rdy[4]) begin
      d4_q    <= dfull_s[DW-1:0];
      pos4_q  <= pos_d;
      clip4_q <= clip_d;
    end
    if (rdy[5]) begin
      qest5_q <= prod5_s[fpq_pkg::RECIP_SH +: QW];
      d5_q    <= d4_q;
      pos5_q  <= pos4_q;
      clip5_q <= clip4_q;
    end
    if (rdy[6]) begin
      prod6_q <= prod6_d;
      qest6_q <= qest5_q;
      d6_q    <= d5_q;
      pos6_q  <= pos5_q;
      clip6_q <= clip5_q;
    end
    if (rdy[7]) begin
      q7_q   <= q7_d;
      pos7_q <= pos6_q;
    end
    if (rdy[8]) begin
      addr8_q <= asum_s[fpq_pkg::FRAC_BITS +: AW];
      pos8_q  <= pos7_q;
    end
    if (rdy[9]) begin
      nits9_q <= pos8_q ? PQ_ROM[addr8_q] : '0;
      pos9_q  <= pos8_q;
    end
  end

`ifndef SYNTHESIS
  a_nits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_nits_o <= fpq_pkg::NITS_MAX))
    else $error("peak above table range");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !peak_valid_o) |-> (peak_nits_o == '0))
    else $error("invalid peak carries nonzero nits");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[MERGE_STG-1] && rdy[MERGE_STG] && last2_q) |=> !seen_q)
    else $error("running max not restarted after frame end");

  a_div_estimate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[6] && pos6_q && !clip6_q) |-> ({1'b0, rem7_s} < {fpq_pkg::DIV_V, 1'b0}))
    else $error("reciprocal estimate off by more than one");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[7] && pos7_q) |-> (q7_q != '0 && q7_q <= fpq_pkg::ONE_V))
    else $error("clamped max outside (0, 1]");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam longint Q30_ONE  = 64'sd1 <<< 30;
  localparam longint LN2_Q30V = 64'sd744261118;
  localparam longint PIX_DEN  = 64'sd78489600000;
  localparam longint FIX_ONE  = 64'sd1 <<< fpq_pkg::FRAC_BITS;
  localparam longint NO_PEAK  = -(64'sd1 <<< (fpq_pkg::FRAC_BITS + 3));
  localparam longint LUT_TOP  = fpq_pkg::PQ_DEPTH - 1;

  localparam logic [15:0] Y_BLACK = {10'd64, 6'd0};
  localparam logic [15:0] Y_WHITE = {10'd940, 6'd0};
  localparam logic [15:0] C_MID   = {10'd512, 6'd0};

  typedef struct packed {
    logic [fpq_pkg::NITS_W-1:0] nits;
    logic                       valid;
  } peak_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic [fpq_pkg::WORD_W-1:0]   luma_word_i  = '0;
  logic [fpq_pkg::WORD_W-1:0]   cb_word_i    = '0;
  logic [fpq_pkg::WORD_W-1:0]   cr_word_i    = '0;
  logic                         frame_last_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic [fpq_pkg::NITS_W-1:0]   peak_nits_o;
  logic                         peak_valid_o;

  logic [fpq_pkg::NITS_W-1:0] eotf_lut [fpq_pkg::PQ_DEPTH];
  longint frame_peak     = NO_PEAK;
  peak_t  pending_peaks [$];
  int     mismatch_count = 0;
  int     tx_idle_pct    = 0;
  int     rx_idle_pct    = 0;

  p010_frame_peak_pq_nits DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .luma_word_i  (luma_word_i),
    .cb_word_i    (cb_word_i),
    .cr_word_i    (cr_word_i),
    .frame_last_i (frame_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .peak_nits_o  (peak_nits_o),
    .peak_valid_o (peak_valid_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint log2_fix30(longint x_in);
    longint x;
    longint shifts;
    longint bits;
    x      = x_in;
    shifts = 0;
    bits   = 0;
    while (x < Q30_ONE) begin
      x = x <<< 1;
      shifts++;
    end
    for (int i = 29; i >= 0; i--) begin
      x = (x * x) >>> 30;
      if (x >= 2 * Q30_ONE) begin
        x    = x >>> 1;
        bits = bits | (64'sd1 <<< i);
      end
    end
    return bits - shifts * Q30_ONE;
  endfunction

  function automatic longint exp2_fix30(longint v);
    longint mag;
    longint whole;
    longint lnx;
    longint acc;
    longint term;
    mag   = -v;
    whole = mag >>> 30;
    lnx   = ((mag & (Q30_ONE - 1)) * LN2_Q30V) >>> 30;
    acc   = Q30_ONE;
    term  = Q30_ONE;
    for (int k = 1; k < 24 && term > 0; k++) begin
      term = ((term * lnx) >>> 30) / k;
      acc  = acc + term;
    end
    if (whole >= 62) return 0;
    return ((64'sd1 <<< 60) / acc) >>> whole;
  endfunction

  function automatic longint pow_fix30(longint x, longint p, longint q);
    longint lg;
    lg = round_div(log2_fix30(x) * p, q);
    if (lg > 0) lg = 0;
    return exp2_fix30(lg);
  endfunction

  function automatic longint pq_eotf_nits(longint e_in);
    longint e;
    longint ep;
    longint num;
    longint den;
    longint ratio;
    longint nits;
    e = e_in;
    if (e <= 0) return 0;
    if (e > Q30_ONE) e = Q30_ONE;
    ep  = pow_fix30(e, 32, 2523);
    num = ep - (64'sd107 <<< 23);
    if (num <= 0) return 0;
    den   = (64'sd2413 <<< 23) - ((64'sd2392 * ep) >>> 7);
    ratio = (num <<< 30) / den;
    if (ratio <= 0) return 0;
    if (ratio > Q30_ONE) ratio = Q30_ONE;
    nits = (pow_fix30(ratio, 8192, 1305) * 10000 + (Q30_ONE >>> 1)) >>> 30;
    return (nits > 10000) ? 10000 : nits;
  endfunction

  // BT.2020 NCL, all three channels over one common denominator
  function automatic longint pixel_rgb_max(input logic [15:0] yw, input logic [15:0] cbw,
                                           input logic [15:0] crw);
    longint y;
    longint cb;
    longint cr;
    longint yt;
    longint r;
    longint g;
    longint b;
    longint m;
    y  = longint'(yw[15:6]);
    cb = longint'(cbw[15:6]);
    cr = longint'(crw[15:6]);
    y  = y - 64;
    cb = cb - 512;
    cr = cr - 512;
    yt = y * 64'sd89600000;
    r  = round_div((yt + 64'sd147460 * 876 * cr) * FIX_ONE, PIX_DEN);
    g  = round_div((yt - 64'sd16455 * 876 * cb - 64'sd57135 * 876 * cr) * FIX_ONE, PIX_DEN);
    b  = round_div((yt + 64'sd188140 * 876 * cb) * FIX_ONE, PIX_DEN);
    m  = (r > g) ? r : g;
    return (b > m) ? b : m;
  endfunction

  function automatic void predict_frame_peak(input logic [15:0] yw, input logic [15:0] cbw,
                                             input logic [15:0] crw, input logic frame_end);
    longint m;
    longint addr;
    peak_t  res;
    m = pixel_rgb_max(yw, cbw, crw);
    if (m > frame_peak) frame_peak = m;
    if (!frame_end) return;
    m          = frame_peak;
    frame_peak = NO_PEAK;
    res        = '0;
    if (m > 0) begin
      if (m > FIX_ONE) m = FIX_ONE;
      addr = (m * LUT_TOP + (FIX_ONE >>> 1)) >>> fpq_pkg::FRAC_BITS;
      if (addr > LUT_TOP) addr = LUT_TOP;
      res.nits  = eotf_lut[addr];
      res.valid = 1'b1;
    end
    pending_peaks.push_back(res);
  endfunction

  function automatic logic [15:0] code_word(int lo, int hi);
    return {10'($urandom_range(hi, lo)), 6'($urandom_range(63))};
  endfunction

  task automatic send_sample(input logic [15:0] yw, input logic [15:0] cbw,
                             input logic [15:0] crw, input logic frame_end);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    luma_word_i  <= yw;
    cb_word_i    <= cbw;
    cr_word_i    <= crw;
    frame_last_i <= frame_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_frame_peak(yw, cbw, crw, frame_end);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_peaks.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    peak_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_peaks.size() == 0) begin
        $display("%0t unexpected result: peak_nits %0d peak_valid %0b",
                 $time, peak_nits_o, peak_valid_o);
        mismatch_count++;
      end else begin
        want = pending_peaks.pop_front();
        if (peak_nits_o !== want.nits) begin
          $display("%0t peak_nits expected %0d actual %0d", $time, want.nits, peak_nits_o);
          mismatch_count++;
        end
        if (peak_valid_o !== want.valid) begin
          $display("%0t peak_valid expected %0b actual %0b", $time, want.valid, peak_valid_o);
          mismatch_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic test_corner_pixels();
    send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1);
    // mid-grey black: max exactly zero, then below zero
    send_sample(Y_BLACK, C_MID, C_MID, 1'b1);
    send_sample({10'd0, 6'd0}, C_MID, C_MID, 1'b1);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(Y_WHITE, C_MID, C_MID, 1'b1);
    send_sample(16'h003F, 16'h803F, 16'h803F, 1'b1);
    send_sample({10'd65, 6'h3F}, C_MID, C_MID, 1'b1);
    send_sample(Y_BLACK, C_MID, {10'd1023, 6'd0}, 1'b1);
    send_sample(Y_BLACK, {10'd1023, 6'd0}, C_MID, 1'b1);
    send_sample(Y_BLACK, 16'h0000, 16'h0000, 1'b1);
    // peak not on the closing pixel
    send_sample({10'd500, 6'd0}, C_MID, C_MID, 1'b0);
    send_sample({10'd800, 6'd0}, C_MID, C_MID, 1'b0);
    send_sample({10'd300, 6'd0}, C_MID, C_MID, 1'b0);
    send_sample({10'd100, 6'd0}, C_MID, C_MID, 1'b1);
    send_sample({10'd0, 6'd0}, C_MID, C_MID, 1'b0);
    send_sample(Y_BLACK, C_MID, C_MID, 1'b0);
    send_sample({10'd10, 6'd0}, C_MID, C_MID, 1'b1);
    send_sample(16'hFFC0, 16'h0000, 16'hFFC0, 1'b0);
    send_sample(16'hFFC0, 16'hFFC0, 16'h0000, 1'b1);
    send_sample(16'hAAAA, 16'h5555, 16'hCCCC, 1'b0);
    send_sample(16'h5555, 16'hAAAA, 16'h3333, 1'b1);
  endtask

  task automatic test_random_frames(input int n_items);
    int          sent;
    int          len;
    int          style;
    logic [15:0] yw;
    logic [15:0] cbw;
    logic [15:0] crw;
    sent = 0;
    while (sent < n_items) begin
      len   = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(48, 13);
      style = $urandom_range(9);
      for (int i = 0; i < len && sent < n_items; i++) begin
        if (style < 2 || (style >= 4 && $urandom_range(9) == 0)) begin
          yw  = 16'($urandom);
          cbw = 16'($urandom);
          crw = 16'($urandom);
        end else if (style < 4) begin
          yw  = code_word(0, 90);
          cbw = code_word(490, 534);
          crw = code_word(490, 534);
        end else if (style < 5) begin
          yw  = code_word(850, 1023);
          cbw = code_word(0, 1023);
          crw = code_word(0, 1023);
        end else begin
          yw  = code_word(64, 940);
          cbw = code_word(64, 960);
          crw = code_word(64, 960);
        end
        sent++;
        send_sample(yw, cbw, crw, (i == len - 1) || (sent == n_items));
      end
      if ($urandom_range(11) == 0) wait_results_drained();
    end
  endtask

  task automatic test_pause_for_results();
    send_sample(code_word(64, 940), code_word(64, 960), code_word(64, 960), 1'b0);
    send_sample(code_word(64, 940), code_word(64, 960), code_word(64, 960), 1'b0);
    send_sample(code_word(64, 940), code_word(64, 960), code_word(64, 960), 1'b1);
    wait_results_drained();
    send_sample(code_word(0, 1023), code_word(0, 1023), code_word(0, 1023), 1'b1);
  endtask

  initial begin
    for (int a = 0; a < fpq_pkg::PQ_DEPTH; a++)
      eotf_lut[a] = pq_eotf_nits(round_div(longint'(a) * Q30_ONE, LUT_TOP));
    tx_idle_pct = 36;
    rx_idle_pct = 70;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_pixels();
    test_random_frames(270);
    test_pause_for_results();
    tx_idle_pct = 70;
    rx_idle_pct = 36;
    test_random_frames(270);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_frames(260);
    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
